>>> design/svmm_pkg.sv
// shared widths, codes and constants of the supply voltage mode monitor
package svmm_pkg;

  localparam int MV_W    = 16;
  localparam int MODE_W  = 3;
  localparam int DWELL_W = 8;
  localparam int PHASE_W = 4;
  localparam int DEB_W   = 3;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_MODES = 5;

  // power mode codes
  localparam logic [MODE_W-1:0] MODE_UNDER  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOW    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIGH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OVER   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_TO_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TO_NORMAL  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TO_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TO_OVER   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LOW       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_NORMAL    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_HIGH      = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_OVER      = 8'd7;

  // threshold reset values
  localparam logic [MV_W-1:0] RST_UNDER_TO_LOW   = 16'd7500;
  localparam logic [MV_W-1:0] RST_LOW_TO_NORMAL  = 16'd8500;
  localparam logic [MV_W-1:0] RST_NORMAL_TO_HIGH = 16'd31500;
  localparam logic [MV_W-1:0] RST_HIGH_TO_OVER   = 16'd35500;
  localparam logic [MV_W-1:0] RST_RISE_LOW       = 16'd8500;
  localparam logic [MV_W-1:0] RST_RISE_NORMAL    = 16'd9500;
  localparam logic [MV_W-1:0] RST_RISE_HIGH      = 16'd32500;
  localparam logic [MV_W-1:0] RST_RISE_OVER      = 16'd36500;

  // fixed behavior constants
  localparam logic [DWELL_W-1:0] CONFIRM_TICKS      = 8'd5;
  localparam logic [MV_W-1:0]    STARTUP_WAIT_TICKS = 16'd25;
  localparam logic [MV_W-1:0]    STABLE_FLOOR_MV    = 16'd9000;
  localparam logic [PHASE_W-1:0] FAULT_EVERY_TICKS  = 4'd3;
  localparam logic [DEB_W-1:0]   FAULT_DEBOUNCE     = 3'd4;

  localparam logic [MV_W-1:0] OVER_SET_MV    = 16'd36500;
  localparam logic [MV_W-1:0] OVER_CLEAR_MV  = 16'd35500;
  localparam logic [MV_W-1:0] UNDER_SET_MV   = 16'd8500;
  localparam logic [MV_W-1:0] UNDER_CLEAR_MV = 16'd9500;
  localparam logic [MV_W-1:0] FULL_SCALE_MV  = 16'hFFFF;

endpackage

>>> design/supply_voltage_mode_monitor.sv
// supply voltage mode monitor: hysteretic five-band mode with dwell and fault flags
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------
//  input   | in_valid, in_stall, voltage_mv            | in  | valid & !stall
//  output  | out_valid, out_stall, power_mode, flags   | out | valid & !stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | valid & ready
//
// one request per cycle while the output is not stalled; a request passes the input register,
// then one pass of compare and count logic into the result register
// synchronous active-high reset puts thresholds at defaults, mode at normal, counters clear
// a stalled output holds its result; the input register stalls only when it is full and
// the result register cannot take its result in the same cycle
module supply_voltage_mode_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [svmm_pkg::MV_W-1:0]       voltage_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [svmm_pkg::MODE_W-1:0]     power_mode,
  output logic                            supply_stable,
  output logic                            over_fault,
  output logic                            under_fault,
  output logic                            over_fault_changed,
  output logic                            under_fault_changed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [svmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svmm_pkg::MV_W-1:0]       cfg_data
);
  import svmm_pkg::*;

  // thresholds
  logic [MV_W-1:0] under_to_low_mv, low_to_normal_mv, normal_to_high_mv, high_to_over_mv;
  logic [MV_W-1:0] rise_low_mv, rise_normal_mv, rise_high_mv, rise_over_mv;

  // input register
  logic            s1_valid;
  logic [MV_W-1:0] s1_v;

  // monitor state
  logic [MODE_W-1:0]  mode_reg, mode_reg_next;
  logic [DWELL_W-1:0] dwell_counts [NUM_MODES];
  logic [DWELL_W-1:0] dwell_counts_next [NUM_MODES];
  logic [MV_W-1:0]    startup_count, startup_count_next;
  logic               stable_flag, stable_flag_next;
  logic [PHASE_W-1:0] fault_phase, fault_phase_next;
  logic               over_flag, over_flag_next, under_flag, under_flag_next;
  logic [DEB_W-1:0]   over_deb, over_deb_next, under_deb, under_deb_next;

  logic advance, fire;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign fire      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;

  // band limits, leave decision and target band
  logic [MODE_W-1:0] cur_mode, target;
  logic [MV_W-1:0]   bmin, bmax;
  logic              fall, rise;
  logic [PHASE_W-1:0] phase_inc;
  logic              run_fault, over_cond, under_cond;
  logic [DEB_W-1:0]  over_deb_inc, under_deb_inc;

  always_comb begin
    cur_mode = (mode_reg > MODE_OVER) ? MODE_NORMAL : mode_reg;
    unique case (cur_mode)
      MODE_UNDER: begin bmin = '0;                bmax = low_to_normal_mv; end
      MODE_LOW:   begin bmin = under_to_low_mv;   bmax = rise_normal_mv;   end
      MODE_NORMAL: begin bmin = low_to_normal_mv; bmax = rise_high_mv;     end
      MODE_HIGH:  begin bmin = normal_to_high_mv; bmax = rise_over_mv;     end
      default:    begin bmin = high_to_over_mv;   bmax = FULL_SCALE_MV;    end
    endcase
    fall = s1_v < bmin;
    rise = !fall && (s1_v >= bmax);
    if (fall) begin
      if (s1_v < under_to_low_mv)        target = MODE_UNDER;
      else if (s1_v < low_to_normal_mv)  target = MODE_LOW;
      else if (s1_v < normal_to_high_mv) target = MODE_NORMAL;
      else if (s1_v < high_to_over_mv)   target = MODE_HIGH;
      else                               target = MODE_OVER;
    end else begin
      if (s1_v >= rise_over_mv)          target = MODE_OVER;
      else if (s1_v >= rise_high_mv)     target = MODE_HIGH;
      else if (s1_v >= rise_normal_mv)   target = MODE_NORMAL;
      else if (s1_v >= rise_low_mv)      target = MODE_LOW;
      else                               target = MODE_UNDER;
    end
  end

  always_comb begin
    // startup wait and sticky stable flag
    startup_count_next = startup_count;
    stable_flag_next   = stable_flag;
    if (startup_count < STARTUP_WAIT_TICKS) begin
      startup_count_next = startup_count + 16'd1;
    end else if (stable_flag || s1_v >= STABLE_FLOOR_MV) begin
      stable_flag_next = 1'b1;
    end

    mode_reg_next = mode_reg;
    for (int i = 0; i < NUM_MODES; i++) begin
      dwell_counts_next[i] = dwell_counts[i];
    end
    if (stable_flag_next) begin
      if (fall || rise) begin
        for (int i = 0; i < NUM_MODES; i++) begin
          if (target == MODE_W'(i)) dwell_counts_next[i] = dwell_counts[i] + 8'd1;
          else                      dwell_counts_next[i] = '0;
        end
      end
      // later band wins if more than one reaches the confirm count
      for (int i = 0; i < NUM_MODES; i++) begin
        if (dwell_counts_next[i] == CONFIRM_TICKS) begin
          mode_reg_next        = MODE_W'(i);
          dwell_counts_next[i] = '0;
        end
      end
    end

    // fault monitors run once per FAULT_EVERY_TICKS accepted samples
    phase_inc = fault_phase + 4'd1;
    run_fault = phase_inc >= FAULT_EVERY_TICKS;
    fault_phase_next = run_fault ? '0 : phase_inc;

    over_cond  = over_flag  ? (s1_v < OVER_CLEAR_MV)  : (s1_v > OVER_SET_MV);
    under_cond = under_flag ? (s1_v > UNDER_CLEAR_MV) : (s1_v <= UNDER_SET_MV);
    over_deb_inc  = over_deb + 3'd1;
    under_deb_inc = under_deb + 3'd1;

    over_flag_next  = over_flag;
    under_flag_next = under_flag;
    over_deb_next   = over_deb;
    under_deb_next  = under_deb;
    if (run_fault) begin
      if (!over_cond) begin
        over_deb_next = '0;
      end else if (over_deb_inc >= FAULT_DEBOUNCE) begin
        over_deb_next  = '0;
        over_flag_next = !over_flag;
      end else begin
        over_deb_next = over_deb_inc;
      end
      if (!under_cond) begin
        under_deb_next = '0;
      end else if (under_deb_inc >= FAULT_DEBOUNCE) begin
        under_deb_next  = '0;
        under_flag_next = !under_flag;
      end else begin
        under_deb_next = under_deb_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      under_to_low_mv   <= RST_UNDER_TO_LOW;
      low_to_normal_mv  <= RST_LOW_TO_NORMAL;
      normal_to_high_mv <= RST_NORMAL_TO_HIGH;
      high_to_over_mv   <= RST_HIGH_TO_OVER;
      rise_low_mv       <= RST_RISE_LOW;
      rise_normal_mv    <= RST_RISE_NORMAL;
      rise_high_mv      <= RST_RISE_HIGH;
      rise_over_mv      <= RST_RISE_OVER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UNDER_TO_LOW:   under_to_low_mv   <= cfg_data;
        REG_LOW_TO_NORMAL:  low_to_normal_mv  <= cfg_data;
        REG_NORMAL_TO_HIGH: normal_to_high_mv <= cfg_data;
        REG_HIGH_TO_OVER:   high_to_over_mv   <= cfg_data;
        REG_RISE_LOW:       rise_low_mv       <= cfg_data;
        REG_RISE_NORMAL:    rise_normal_mv    <= cfg_data;
        REG_RISE_HIGH:      rise_high_mv      <= cfg_data;
        REG_RISE_OVER:      rise_over_mv      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_v <= voltage_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_NORMAL;
      startup_count <= '0;
      stable_flag   <= 1'b0;
      fault_phase   <= '0;
      over_flag     <= 1'b0;
      under_flag    <= 1'b0;
      over_deb      <= '0;
      under_deb     <= '0;
      for (int i = 0; i < NUM_MODES; i++) begin
        dwell_counts[i] <= '0;
      end
    end else if (fire) begin
      mode_reg      <= mode_reg_next;
      startup_count <= startup_count_next;
      stable_flag   <= stable_flag_next;
      fault_phase   <= fault_phase_next;
      over_flag     <= over_flag_next;
      under_flag    <= under_flag_next;
      over_deb      <= over_deb_next;
      under_deb     <= under_deb_next;
      for (int i = 0; i < NUM_MODES; i++) begin
        dwell_counts[i] <= dwell_counts_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      power_mode          <= mode_reg_next;
      supply_stable       <= stable_flag_next;
      over_fault          <= over_flag_next;
      under_fault         <= under_flag_next;
      over_fault_changed  <= over_flag_next != over_flag;
      under_fault_changed <= under_flag_next != under_flag;
    end
  end

  logic [NUM_MODES-1:0] dwell_busy;
  always_comb begin
    for (int i = 0; i < NUM_MODES; i++) begin
      dwell_busy[i] = dwell_counts[i] != '0;
    end
  end

  a_stable_sticky: assert property (@(posedge clk) disable iff (rst)
    stable_flag |=> stable_flag)
    else $error("stable flag dropped");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    fault_phase < FAULT_EVERY_TICKS)
    else $error("fault phase out of range");

  a_one_dwell: assert property (@(posedge clk) disable iff (rst)
    $countones(dwell_busy) <= 1)
    else $error("more than one dwell counter running");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !supply_stable |-> power_mode == MODE_NORMAL)
    else $error("mode left normal before supply stable");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode_reg <= MODE_OVER)
    else $error("mode register out of range");

endmodule

>>> test/svmm_status_checker.sv
// checker for the supply voltage mode monitor: predicts every status result and compares it
module svmm_status_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [svmm_pkg::MV_W-1:0]       voltage_mv,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [svmm_pkg::MODE_W-1:0]     power_mode,
  input  logic                            supply_stable,
  input  logic                            over_fault,
  input  logic                            under_fault,
  input  logic                            over_fault_changed,
  input  logic                            under_fault_changed,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [svmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svmm_pkg::MV_W-1:0]       cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import svmm_pkg::*;

  localparam int NUM_REGS    = 8;
  localparam int LIM_IDX_W   = $clog2(NUM_REGS);
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              stable;
    logic              over;
    logic              under;
    logic              over_chg;
    logic              under_chg;
  } supply_status_t;

  supply_status_t     status_q[$];
  logic [MV_W-1:0]    lim_mv [NUM_REGS];
  logic [MODE_W-1:0]  cur_mode;
  logic [DWELL_W-1:0] dwell [NUM_MODES];
  logic [MV_W-1:0]    warmup_cnt;
  logic               stable;
  logic [PHASE_W-1:0] fault_tick;
  logic               over_flag;
  logic               under_flag;
  logic [DEB_W-1:0]   over_deb;
  logic [DEB_W-1:0]   under_deb;
  int                 results_seen;

  task report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH at result %0d: %s", results_seen, msg);
    end
  endtask

  task check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic logic [MV_W-1:0] lim(input logic [CFG_IDX_W-1:0] idx);
    return lim_mv[idx[LIM_IDX_W-1:0]];
  endfunction

  // returns {flag, count} after one monitor evaluation
  function automatic logic [DEB_W:0] debounce(input logic cond, input logic flag,
                                              input logic [DEB_W-1:0] cnt);
    logic [DEB_W-1:0] n;
    logic             f;
    f = flag;
    n = '0;
    if (cond) begin
      n = cnt + 1'b1;
      if (n >= FAULT_DEBOUNCE) begin
        n = '0;
        f = ~flag;
      end
    end
    return {f, n};
  endfunction

  function automatic logic [MV_W-1:0] band_floor(input logic [MODE_W-1:0] m);
    case (m)
      MODE_UNDER:  return '0;
      MODE_LOW:    return lim(REG_UNDER_TO_LOW);
      MODE_NORMAL: return lim(REG_LOW_TO_NORMAL);
      MODE_HIGH:   return lim(REG_NORMAL_TO_HIGH);
      default:     return lim(REG_HIGH_TO_OVER);
    endcase
  endfunction

  function automatic logic [MV_W-1:0] band_ceiling(input logic [MODE_W-1:0] m);
    case (m)
      MODE_UNDER:  return lim(REG_LOW_TO_NORMAL);
      MODE_LOW:    return lim(REG_RISE_NORMAL);
      MODE_NORMAL: return lim(REG_RISE_HIGH);
      MODE_HIGH:   return lim(REG_RISE_OVER);
      default:     return FULL_SCALE_MV;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] falling_target(input logic [MV_W-1:0] v);
    if (v < lim(REG_UNDER_TO_LOW)) return MODE_UNDER;
    else if (v < lim(REG_LOW_TO_NORMAL)) return MODE_LOW;
    else if (v < lim(REG_NORMAL_TO_HIGH)) return MODE_NORMAL;
    else if (v < lim(REG_HIGH_TO_OVER)) return MODE_HIGH;
    else return MODE_OVER;
  endfunction

  function automatic logic [MODE_W-1:0] rising_target(input logic [MV_W-1:0] v);
    if (v >= lim(REG_RISE_OVER)) return MODE_OVER;
    else if (v >= lim(REG_RISE_HIGH)) return MODE_HIGH;
    else if (v >= lim(REG_RISE_NORMAL)) return MODE_NORMAL;
    else if (v >= lim(REG_RISE_LOW)) return MODE_LOW;
    else return MODE_UNDER;
  endfunction

  function automatic supply_status_t predict_status(input logic [MV_W-1:0] v);
    supply_status_t    s;
    logic [MODE_W-1:0] m;
    logic [MODE_W-1:0] tgt;
    logic              left_band;
    logic              old_over;
    logic              old_under;
    old_over  = over_flag;
    old_under = under_flag;
    tgt       = MODE_NORMAL;

    // the floor is not looked at on a tick that still counts the startup wait
    if (warmup_cnt < STARTUP_WAIT_TICKS) warmup_cnt = warmup_cnt + 1'b1;
    else if (stable || v >= STABLE_FLOOR_MV) stable = 1'b1;

    if (stable) begin
      m = (cur_mode > MODE_OVER) ? MODE_NORMAL : cur_mode;
      left_band = 1'b1;
      if (v < band_floor(m)) tgt = falling_target(v);
      else if (v >= band_ceiling(m)) tgt = rising_target(v);
      else left_band = 1'b0;
      // in band: partial dwell counts are kept
      if (left_band) begin
        for (int i = 0; i < NUM_MODES; i++) begin
          dwell[i] = (i == tgt) ? dwell[i] + 1'b1 : '0;
        end
      end
      for (int i = 0; i < NUM_MODES; i++) begin
        if (dwell[i] == CONFIRM_TICKS) begin
          cur_mode = i[MODE_W-1:0];
          dwell[i] = '0;
        end
      end
    end

    fault_tick = fault_tick + 1'b1;
    if (fault_tick >= FAULT_EVERY_TICKS) begin
      fault_tick = '0;
      {over_flag, over_deb} = debounce(over_flag ? (v < OVER_CLEAR_MV) : (v > OVER_SET_MV),
                                       over_flag, over_deb);
      {under_flag, under_deb} = debounce(under_flag ? (v > UNDER_CLEAR_MV)
                                                    : (v <= UNDER_SET_MV),
                                         under_flag, under_deb);
    end

    s.mode      = cur_mode;
    s.stable    = stable;
    s.over      = over_flag;
    s.under     = under_flag;
    s.over_chg  = over_flag != old_over;
    s.under_chg = under_flag != old_under;
    return s;
  endfunction

  always @(posedge clk) begin
    supply_status_t want;
    if (rst) begin
      lim_mv = '{RST_UNDER_TO_LOW, RST_LOW_TO_NORMAL, RST_NORMAL_TO_HIGH, RST_HIGH_TO_OVER,
                 RST_RISE_LOW, RST_RISE_NORMAL, RST_RISE_HIGH, RST_RISE_OVER};
      cur_mode = MODE_NORMAL;
      for (int i = 0; i < NUM_MODES; i++) dwell[i] = '0;
      warmup_cnt = '0;
      stable     = 1'b0;
      fault_tick = '0;
      over_flag  = 1'b0;
      under_flag = 1'b0;
      over_deb   = '0;
      under_deb  = '0;
      mismatches   = 0;
      results_seen = 0;
      status_q.delete();
    end else begin
      // unknown register indexes are ignored
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
        lim_mv[cfg_index[LIM_IDX_W-1:0]] = cfg_data;
      end
      if (in_valid && !in_stall) status_q.push_back(predict_status(voltage_mv));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_q.size() == 0) begin
          report("result with no request waiting");
        end else begin
          want = status_q.pop_front();
          check_field("power_mode", int'(power_mode), int'(want.mode));
          check_field("supply_stable", int'(supply_stable), int'(want.stable));
          check_field("over_fault", int'(over_fault), int'(want.over));
          check_field("under_fault", int'(under_fault), int'(want.under));
          check_field("over_fault_changed", int'(over_fault_changed), int'(want.over_chg));
          check_field("under_fault_changed", int'(under_fault_changed),
                      int'(want.under_chg));
        end
      end
    end
    outstanding <= status_q.size();
  end

endmodule

>>> test/supply_voltage_mode_monitor_tb.sv
// testbench top for the supply voltage mode monitor: stimulus, stalls and verdict
module supply_voltage_mode_monitor_tb;
  import svmm_pkg::*;

  localparam int NUM_REGS      = 8;
  localparam int LIM_IDX_W     = $clog2(NUM_REGS);
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 500000;

  // threshold setting kinds
  localparam int SET_DEFAULT   = 0;
  localparam int SET_ZERO      = 1;
  localparam int SET_FULL      = 2;
  localparam int SET_ORDERED   = 3;
  localparam int SET_SCRAMBLED = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MV_W-1:0]      voltage_mv = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MODE_W-1:0]    power_mode;
  logic                 supply_stable;
  logic                 over_fault;
  logic                 under_fault;
  logic                 over_fault_changed;
  logic                 under_fault_changed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MV_W-1:0]      cfg_data = '0;
  int                   mismatches;
  int                   outstanding;

  int                   in_idle_pct = 36;
  int                   out_idle_pct = 76;
  int                   cycle_cnt = 0;
  logic [MV_W-1:0]      cur_lim [NUM_REGS];

  supply_voltage_mode_monitor dut (.*);

  svmm_status_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task send_sample(input logic [MV_W-1:0] v);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    voltage_mv <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_REGS) cur_lim[idx[LIM_IDX_W-1:0]] = data;
  endtask

  task wait_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task load_settings(input int kind);
    logic [MV_W-1:0] v;
    case (kind)
      SET_DEFAULT: begin
        write_reg(REG_UNDER_TO_LOW, RST_UNDER_TO_LOW);
        write_reg(REG_LOW_TO_NORMAL, RST_LOW_TO_NORMAL);
        write_reg(REG_NORMAL_TO_HIGH, RST_NORMAL_TO_HIGH);
        write_reg(REG_HIGH_TO_OVER, RST_HIGH_TO_OVER);
        write_reg(REG_RISE_LOW, RST_RISE_LOW);
        write_reg(REG_RISE_NORMAL, RST_RISE_NORMAL);
        write_reg(REG_RISE_HIGH, RST_RISE_HIGH);
        write_reg(REG_RISE_OVER, RST_RISE_OVER);
      end
      SET_ZERO: begin
        for (int i = 0; i < NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], '0);
      end
      SET_FULL: begin
        for (int i = 0; i < NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], FULL_SCALE_MV);
      end
      SET_ORDERED: begin
        // well-formed ladder with random gaps, each falling level at or below its rising one
        v = MV_W'($urandom_range(0, 8000));
        write_reg(REG_UNDER_TO_LOW, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_RISE_LOW, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_LOW_TO_NORMAL, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_RISE_NORMAL, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_NORMAL_TO_HIGH, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_RISE_HIGH, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_HIGH_TO_OVER, v);
        v = v + MV_W'($urandom_range(0, 8000));
        write_reg(REG_RISE_OVER, v);
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++) begin
          v = MV_W'($urandom);
          write_reg(i[CFG_IDX_W-1:0], v);
        end
      end
    endcase
    // a write to an index past the register list must leave everything alone
    v = MV_W'($urandom);
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), v);
    cfg_valid <= 1'b0;
  endtask

  // mostly levels near a threshold, some full-range noise and the scale ends
  function automatic logic [MV_W-1:0] pick_level();
    int              r;
    logic [MV_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      base = MV_W'($urandom);
      return base;
    end
    if (r < 20) return $urandom_range(0, 1) ? FULL_SCALE_MV : '0;
    r = $urandom_range(0, 12);
    if (r < NUM_REGS) base = cur_lim[r[LIM_IDX_W-1:0]];
    else if (r == 8) base = OVER_SET_MV;
    else if (r == 9) base = OVER_CLEAR_MV;
    else if (r == 10) base = UNDER_SET_MV;
    else if (r == 11) base = UNDER_CLEAR_MV;
    else base = STABLE_FLOOR_MV;
    return MV_W'(base + $urandom_range(0, 6) - 3);
  endfunction

  initial begin
    int              count;
    int              run;
    int              kind;
    logic [MV_W-1:0] level;

    cur_lim = '{RST_UNDER_TO_LOW, RST_LOW_TO_NORMAL, RST_NORMAL_TO_HIGH, RST_HIGH_TO_OVER,
                RST_RISE_LOW, RST_RISE_NORMAL, RST_RISE_HIGH, RST_RISE_OVER};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // startup wait: full scale sets the over fault, zero clears it and sets under
    repeat (12) send_sample(FULL_SCALE_MV);
    repeat (12) send_sample('0);
    send_sample(16'hAAAA);
    // first tick after the wait, below the floor, then above it
    send_sample(STABLE_FLOOR_MV - 1'b1);
    send_sample(16'h5555);
    // top of scale leaves the normal band rising and confirms over
    repeat (5) send_sample(FULL_SCALE_MV);
    wait_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 3) begin
        in_idle_pct  = 36;
        out_idle_pct = 76;
      end else if (phase < 6) begin
        in_idle_pct  = 76;
        out_idle_pct = 36;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (phase)
        0: kind = SET_DEFAULT;
        1: kind = SET_ORDERED;
        2: kind = SET_SCRAMBLED;
        3: kind = SET_ZERO;
        4: kind = SET_FULL;
        5: kind = SET_ORDERED;
        6: kind = SET_SCRAMBLED;
        default: kind = SET_DEFAULT;
      endcase
      load_settings(kind);
      count = 0;
      while (count < PHASE_ITEMS) begin
        // hold a level for a run of samples, some long enough for dwell confirmation and fault debounce
        level = pick_level();
        run = $urandom_range(1, 14);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) send_sample(pick_level());
          else send_sample(level);
          count++;
        end
      end
      wait_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/svmm_pkg.sv
design/supply_voltage_mode_monitor.sv
test/svmm_status_checker.sv
test/supply_voltage_mode_monitor_tb.sv
